// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/c8ic_pkg.sv =====
// ----------------------------------------------------------------------------
// c8ic_pkg
// Types, sizes and codes shared by the CHIP-8 instruction core.
// ----------------------------------------------------------------------------
`default_nettype none

package c8ic_pkg;

  // Machine sizes
  localparam int MEMORY_BYTES  = 4096;
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int STACK_DEPTH   = 16;
  localparam int NUM_REGS      = 16;

  localparam int ADDR_W  = 12;
  localparam int MEM_AW  = $clog2(MEMORY_BYTES);
  localparam int SW_B    = $clog2(SCREEN_WIDTH);
  localparam int SH_B    = $clog2(SCREEN_HEIGHT);
  localparam int SCR_AW  = SW_B + SH_B;
  localparam int SCR_PIX = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int SP_W    = $clog2(STACK_DEPTH);
  localparam int REG_AW  = $clog2(NUM_REGS);

  localparam logic [ADDR_W-1:0] START_RESET = 12'd512;

  // Commands
  localparam logic [2:0] CMD_LOAD    = 3'd0;
  localparam logic [2:0] CMD_EXEC    = 3'd1;
  localparam logic [2:0] CMD_PIXEL   = 3'd2;
  localparam logic [2:0] CMD_REG     = 3'd3;
  localparam logic [2:0] CMD_RESTART = 3'd4;

  // Opcode groups (top nibble)
  localparam logic [3:0] OP_SYS   = 4'h0;
  localparam logic [3:0] OP_JP    = 4'h1;
  localparam logic [3:0] OP_CALL  = 4'h2;
  localparam logic [3:0] OP_SE    = 4'h3;
  localparam logic [3:0] OP_SNE   = 4'h4;
  localparam logic [3:0] OP_SER   = 4'h5;
  localparam logic [3:0] OP_LD    = 4'h6;
  localparam logic [3:0] OP_ADD   = 4'h7;
  localparam logic [3:0] OP_ALU   = 4'h8;
  localparam logic [3:0] OP_SNER  = 4'h9;
  localparam logic [3:0] OP_LDI   = 4'hA;
  localparam logic [3:0] OP_DRW   = 4'hD;

  localparam logic [15:0] OPC_CLS = 16'h00E0;
  localparam logic [15:0] OPC_RET = 16'h00EE;

  // 8xyN sub-operations
  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SUBN = 4'h7;

  localparam logic [REG_AW-1:0] REG_VF = 4'hF;

  typedef struct packed {
    logic [2:0]  command;
    logic [11:0] mem_address;
    logic [7:0]  mem_data;
    logic [5:0]  pixel_column;
    logic [4:0]  pixel_row;
    logic [3:0]  reg_select;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  read_value;
    logic [11:0] program_counter;
    logic [11:0] index_value;
    logic        screen_changed;
    logic        unsupported_op;
  } out_res_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH_LO,
    S_READ_X,
    S_READ_Y,
    S_EXEC,
    S_RET,
    S_FLAG,
    S_DRAW_ROW,
    S_DRAW_BYTE,
    S_DRAW_PIX,
    S_DRAW_WR,
    S_READ_PIX,
    S_READ_REG,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/c8ic_ram.sv =====
// ----------------------------------------------------------------------------
// c8ic_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module c8ic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/chip8_instruction_core.sv =====
// ----------------------------------------------------------------------------
// chip8_instruction_core
// CHIP-8 interpreter core: memory, registers, stack and screen in RAMs,
// one command request in, one result out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall | in_data (in_req_t)
//  cfg     | input     | cfg_write_en        | cfg_write_data (start address)
//  out     | output    | out_valid/out_stall | out_data (out_res_t)
//
// Draw reads each sprite row, then walks its columns; each set sprite bit
// costs a screen RAM read-modify-write. Clear writes one pixel a cycle.
// After reset the screen RAM is swept; in_stall stays high.
// The next request is taken while a result waits on a stalled out channel.
`default_nettype none
`include "assert_macros.svh"

module chip8_instruction_core
  import c8ic_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_en,
  input  wire logic [11:0] cfg_write_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_req_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_res_t         out_data
);

  state_t state, state_next;

  logic [ADDR_W-1:0] start_addr, pc, idx;
  logic [SP_W-1:0]   sp;
  logic [15:0]       op;
  logic [7:0]        vx, vy, sprite, rv;
  logic [3:0]        row, col;
  logic              flag, scr_chg, unsup, clr_op;
  logic [SCR_AW-1:0] clr_cnt;
  logic [NUM_REGS-1:0] reg_valid;
  logic              reg_rvld;

  // RAM ports
  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;
  logic              scr_we;
  logic [SCR_AW-1:0] scr_waddr, scr_raddr;
  logic              scr_wdata, scr_rdata;
  logic              reg_we;
  logic [REG_AW-1:0] reg_waddr, reg_raddr;
  logic [7:0]        reg_wdata, reg_rdata;
  logic              stk_we;
  logic [SP_W-1:0]   stk_waddr, stk_raddr;
  logic [ADDR_W-1:0] stk_wdata, stk_rdata;

  c8ic_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );
  c8ic_ram #(.WIDTH(1), .DEPTH(SCR_PIX)) u_scr (
    .clk(clk), .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
    .raddr(scr_raddr), .rdata(scr_rdata)
  );
  c8ic_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_regs (
    .clk(clk), .we(reg_we), .waddr(reg_waddr), .wdata(reg_wdata),
    .raddr(reg_raddr), .rdata(reg_rdata)
  );
  c8ic_ram #(.WIDTH(ADDR_W), .DEPTH(STACK_DEPTH)) u_stk (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  // Decoded fields and helpers
  logic [3:0]        op_grp, op_x, op_y, op_n;
  logic [7:0]        op_nn;
  logic [ADDR_W-1:0] op_nnn, pc_p1, pc_p2, pc_p4, sprite_addr;
  logic [7:0]        vy_rd, alu_res;
  logic [8:0]        sum9;
  logic              alu_flag, alu_wr, alu_fl, is_unsup, out_load, accept;
  logic [7:0]        py_sum, px_sum;
  logic [SCR_AW-1:0] draw_k;

  assign op_grp = op[15:12];
  assign op_x   = op[11:8];
  assign op_y   = op[7:4];
  assign op_n   = op[3:0];
  assign op_nn  = op[7:0];
  assign op_nnn = op[11:0];
  assign pc_p1  = pc + 12'd1;
  assign pc_p2  = pc + 12'd2;
  assign pc_p4  = pc + 12'd4;
  assign sprite_addr = idx + {8'd0, row};
  assign vy_rd  = reg_rvld ? reg_rdata : 8'd0;
  assign sum9   = {1'b0, vx} + {1'b0, vy_rd};
  assign py_sum = vy + {4'd0, row};
  assign px_sum = vx + {4'd0, col};
  assign draw_k = {py_sum[SH_B-1:0], px_sum[SW_B-1:0]};
  assign accept = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  // 8xyN result and flag
  always_comb begin
    alu_res  = 8'd0;
    alu_flag = 1'b0;
    alu_wr   = 1'b1;
    alu_fl   = 1'b0;
    case (op_n)
      ALU_MOV:  alu_res = vy_rd;
      ALU_OR:   alu_res = vx | vy_rd;
      ALU_AND:  alu_res = vx & vy_rd;
      ALU_XOR:  alu_res = vx ^ vy_rd;
      ALU_ADD: begin
        alu_res  = sum9[7:0];
        alu_flag = sum9[8];
        alu_fl   = 1'b1;
      end
      ALU_SUB: begin
        alu_res  = vx - vy_rd;
        alu_flag = (vx >= vy_rd);
        alu_fl   = 1'b1;
      end
      ALU_SUBN: begin
        alu_res  = vy_rd - vx;
        alu_flag = (vy_rd >= vx);
        alu_fl   = 1'b1;
      end
      default:  alu_wr = 1'b0;
    endcase
  end

  // Unimplemented opcode detect
  always_comb begin
    case (op_grp)
      OP_SYS:  is_unsup = (op != OPC_CLS) && (op != OPC_RET);
      OP_ALU:  is_unsup = !alu_wr;
      OP_JP, OP_CALL, OP_SE, OP_SNE, OP_SER, OP_LD, OP_ADD, OP_SNER, OP_LDI,
      OP_DRW:  is_unsup = 1'b0;
      default: is_unsup = 1'b1;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and RAM controls
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = in_data.mem_address[MEM_AW-1:0];
    mem_wdata  = in_data.mem_data;
    mem_raddr  = pc[MEM_AW-1:0];
    scr_we     = 1'b0;
    scr_waddr  = clr_cnt;
    scr_wdata  = 1'b0;
    scr_raddr  = draw_k;
    reg_we     = 1'b0;
    reg_waddr  = op_x;
    reg_wdata  = alu_res;
    reg_raddr  = in_data.reg_select;
    stk_we     = 1'b0;
    stk_waddr  = sp;
    stk_wdata  = pc_p2;
    stk_raddr  = sp - 1'b1;
    case (state)
      S_CLEAR: begin
        scr_we = 1'b1;
        if (&clr_cnt) begin
          state_next = clr_op ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        scr_raddr = {in_data.pixel_row[SH_B-1:0], in_data.pixel_column[SW_B-1:0]};
        if (in_valid) begin
          case (in_data.command)
            CMD_LOAD: begin
              mem_we     = 1'b1;
              state_next = S_DONE;
            end
            CMD_EXEC:    state_next = S_FETCH_LO;
            CMD_PIXEL:   state_next = S_READ_PIX;
            CMD_REG:     state_next = S_READ_REG;
            default:     state_next = S_DONE;
          endcase
        end
      end
      S_FETCH_LO: begin
        mem_raddr  = pc_p1[MEM_AW-1:0];
        state_next = S_READ_X;
      end
      S_READ_X: begin
        reg_raddr  = op_x;
        state_next = S_READ_Y;
      end
      S_READ_Y: begin
        reg_raddr  = op_y;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_DONE;
        case (op_grp)
          OP_SYS: begin
            if (op == OPC_CLS) begin
              state_next = S_CLEAR;
            end else if (op == OPC_RET) begin
              state_next = S_RET;
            end
          end
          OP_CALL: stk_we = 1'b1;
          OP_LD: begin
            reg_we    = 1'b1;
            reg_wdata = op_nn;
          end
          OP_ADD: begin
            reg_we    = 1'b1;
            reg_wdata = vx + op_nn;
          end
          OP_ALU: begin
            reg_we = alu_wr;
            if (alu_fl) begin
              state_next = S_FLAG;
            end
          end
          OP_DRW:  state_next = S_DRAW_ROW;
          default: state_next = S_DONE;
        endcase
      end
      S_RET:  state_next = S_DONE;
      S_FLAG: begin
        reg_we     = 1'b1;
        reg_waddr  = REG_VF;
        reg_wdata  = {7'd0, flag};
        state_next = S_DONE;
      end
      S_DRAW_ROW: begin
        mem_raddr = sprite_addr[MEM_AW-1:0];
        if (row == op_n) begin
          state_next = S_FLAG;
        end else begin
          state_next = S_DRAW_BYTE;
        end
      end
      S_DRAW_BYTE: state_next = S_DRAW_PIX;
      S_DRAW_PIX: begin
        if (col[3]) begin
          state_next = S_DRAW_ROW;
        end else if (sprite[7]) begin
          state_next = S_DRAW_WR;
        end
      end
      S_DRAW_WR: begin
        scr_we     = 1'b1;
        scr_waddr  = draw_k;
        scr_wdata  = !scr_rdata;
        state_next = S_DRAW_PIX;
      end
      S_READ_PIX: state_next = S_DONE;
      S_READ_REG: state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_addr <= START_RESET;
      pc         <= START_RESET;
      idx        <= '0;
      sp         <= '0;
      clr_cnt    <= '0;
      clr_op     <= 1'b0;
      reg_valid  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        start_addr <= cfg_write_data;
      end
      if (reg_we) begin
        reg_valid[reg_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        S_IDLE: begin
          clr_op <= 1'b0;
          if (accept && (in_data.command == CMD_RESTART)) begin
            pc  <= start_addr;
            idx <= '0;
            sp  <= '0;
          end
        end
        S_EXEC: begin
          case (op_grp)
            OP_SYS: begin
              pc <= pc_p2;
              if (op == OPC_CLS) begin
                clr_op <= 1'b1;
              end else if (op == OPC_RET) begin
                sp <= sp - 1'b1;
              end
            end
            OP_JP:   pc <= op_nnn;
            OP_CALL: begin
              pc <= op_nnn;
              sp <= sp + 1'b1;
            end
            OP_SE:   pc <= (vx == op_nn) ? pc_p4 : pc_p2;
            OP_SNE:  pc <= (vx != op_nn) ? pc_p4 : pc_p2;
            OP_SER:  pc <= (vx == vy_rd) ? pc_p4 : pc_p2;
            OP_SNER: pc <= (vx != vy_rd) ? pc_p4 : pc_p2;
            OP_LDI: begin
              pc  <= pc_p2;
              idx <= op_nnn;
            end
            default: pc <= pc_p2;
          endcase
        end
        S_RET: pc <= stk_rdata;
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    reg_rvld <= reg_valid[reg_raddr];
    case (state)
      S_IDLE: begin
        rv      <= 8'd0;
        scr_chg <= 1'b0;
        unsup   <= 1'b0;
      end
      S_FETCH_LO: op[15:8] <= mem_rdata;
      S_READ_X:   op[7:0]  <= mem_rdata;
      S_READ_Y:   vx       <= vy_rd;
      S_EXEC: begin
        vy      <= vy_rd;
        unsup   <= is_unsup;
        row     <= 4'd0;
        scr_chg <= (op_grp == OP_DRW) || (op == OPC_CLS);
        // draw collects collisions from zero
        flag    <= (op_grp == OP_DRW) ? 1'b0 : alu_flag;
      end
      S_DRAW_ROW:  col <= 4'd0;
      S_DRAW_BYTE: sprite <= mem_rdata;
      S_DRAW_PIX: begin
        if (col[3]) begin
          row <= row + 4'd1;
        end else if (!sprite[7]) begin
          sprite <= {sprite[6:0], 1'b0};
          col    <= col + 4'd1;
        end
      end
      S_DRAW_WR: begin
        flag   <= flag | scr_rdata;
        sprite <= {sprite[6:0], 1'b0};
        col    <= col + 4'd1;
      end
      S_READ_PIX: rv <= {7'd0, scr_rdata};
      S_READ_REG: rv <= vy_rd;
      default: ;
    endcase
    if (out_load) begin
      out_data.read_value      <= rv;
      out_data.program_counter <= pc;
      out_data.index_value     <= idx;
      out_data.screen_changed  <= scr_chg;
      out_data.unsupported_op  <= unsup;
    end
  end

  // Checks
  `ASSERT_NEXT(a_accept_leaves_idle, accept, state != S_IDLE,
    "accepted request did not start processing")
  `ASSERT_NEXT(a_reg_write_valid, reg_we, reg_valid[$past(reg_waddr)],
    "register write did not mark entry valid")
  `ASSERT_CLK(a_col_range, !((state == S_DRAW_PIX) && (col > 4'd8)),
    "draw column past sprite width")
  `ASSERT_NEXT(a_load_only_done, out_load, out_valid,
    "result load did not raise out_valid")

endmodule

`default_nettype wire

// ===== tb/tb_chip8_instruction_core.sv =====
// ----------------------------------------------------------------------------
// tb_chip8_instruction_core
// Drives command requests into the CHIP-8 core and checks every result
// against an in-bench interpreter model, with random gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_chip8_instruction_core;
  import c8ic_pkg::*;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cfg_write_en = 1'b0;
  logic [11:0] cfg_write_data = '0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_res_t out_data;

  chip8_instruction_core DUT (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Model state
  logic [7:0]  mdl_mem [MEMORY_BYTES];
  bit          mdl_written [MEMORY_BYTES];
  logic [7:0]  mdl_v [16];
  bit          mdl_scr [SCR_PIX];
  logic [11:0] mdl_stack [STACK_DEPTH];
  logic [3:0]  mdl_sp;
  int          stack_used;
  logic [11:0] mdl_pc, mdl_i, mdl_start;

  out_res_t expected_q[$];
  int errors = 0;
  int n_results = 0;
  int n_exec = 0;
  longint cycles = 0;
  bit   stall_free = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR result %0d: %s got %0h expected %0h", n_results, what, got, want);
    errors++;
  endtask

  function automatic logic [7:0] mem_rd(input logic [11:0] a);
    return mdl_mem[a];
  endfunction

  // Interpreter step for one execute request; returns {unsupported, changed}
  function automatic logic [1:0] interpret_op();
    logic [15:0] op;
    logic [3:0]  x, y, n;
    logic [7:0]  vx, vy, nn, spr;
    logic [8:0]  sum;
    bit          flag;
    int          py, px;
    op = {mem_rd(mdl_pc), mem_rd(mdl_pc + 12'd1)};
    x = op[11:8]; y = op[7:4]; n = op[3:0]; nn = op[7:0];
    mdl_pc = mdl_pc + 12'd2;
    vx = mdl_v[x]; vy = mdl_v[y];
    case (op[15:12])
      OP_SYS: begin
        if (op == OPC_CLS) begin
          foreach (mdl_scr[k]) mdl_scr[k] = 1'b0;
          return 2'b01;
        end
        if (op == OPC_RET) begin
          mdl_sp = mdl_sp - 4'd1;
          mdl_pc = mdl_stack[mdl_sp];
          return 2'b00;
        end
        return 2'b10;
      end
      OP_JP: mdl_pc = op[11:0];
      OP_CALL: begin
        mdl_stack[mdl_sp] = mdl_pc;
        mdl_sp = mdl_sp + 4'd1;
        mdl_pc = op[11:0];
      end
      OP_SE:   if (vx == nn) mdl_pc = mdl_pc + 12'd2;
      OP_SNE:  if (vx != nn) mdl_pc = mdl_pc + 12'd2;
      OP_SER:  if (vx == vy) mdl_pc = mdl_pc + 12'd2;
      OP_SNER: if (vx != vy) mdl_pc = mdl_pc + 12'd2;
      OP_LD:   mdl_v[x] = nn;
      OP_ADD:  mdl_v[x] = vx + nn;
      OP_LDI:  mdl_i = op[11:0];
      OP_DRW: begin
        flag = 1'b0;
        for (int r = 0; r < n; r++) begin
          spr = mem_rd(mdl_i + 12'(r));
          py = (vy + r) % SCREEN_HEIGHT;
          for (int c = 0; c < 8; c++) begin
            if (spr[7-c]) begin
              px = (vx + c) % SCREEN_WIDTH;
              if (mdl_scr[py*SCREEN_WIDTH+px]) flag = 1'b1;
              mdl_scr[py*SCREEN_WIDTH+px] ^= 1'b1;
            end
          end
        end
        mdl_v[REG_VF] = {7'd0, flag};
        return 2'b01;
      end
      OP_ALU: begin
        case (n)
          ALU_MOV: mdl_v[x] = vy;
          ALU_OR:  mdl_v[x] = vx | vy;
          ALU_AND: mdl_v[x] = vx & vy;
          ALU_XOR: mdl_v[x] = vx ^ vy;
          ALU_ADD: begin
            sum = vx + vy;
            mdl_v[x] = sum[7:0];
            mdl_v[REG_VF] = {7'd0, sum[8]};
          end
          ALU_SUB: begin
            mdl_v[x] = vx - vy;
            mdl_v[REG_VF] = {7'd0, vx >= vy};
          end
          ALU_SUBN: begin
            mdl_v[x] = vy - vx;
            mdl_v[REG_VF] = {7'd0, vy >= vx};
          end
          default: return 2'b10;
        endcase
      end
      default: return 2'b10;
    endcase
    return 2'b00;
  endfunction

  function automatic out_res_t predict_result(input in_req_t rq);
    out_res_t res;
    logic [1:0] fl;
    res = '0;
    fl = 2'b00;
    case (rq.command)
      CMD_LOAD: begin
        mdl_mem[rq.mem_address] = rq.mem_data;
        mdl_written[rq.mem_address] = 1'b1;
      end
      CMD_EXEC: fl = interpret_op();
      CMD_PIXEL: res.read_value = {7'd0, mdl_scr[rq.pixel_row*SCREEN_WIDTH + rq.pixel_column]};
      CMD_REG: res.read_value = mdl_v[rq.reg_select];
      CMD_RESTART: begin
        mdl_pc = mdl_start; mdl_i = '0; mdl_sp = '0; stack_used = 0;
      end
      default: ;
    endcase
    res.program_counter = mdl_pc;
    res.index_value = mdl_i;
    res.screen_changed = fl[0];
    res.unsupported_op = fl[1];
    return res;
  endfunction

  function automatic int gap_len();
    if (stall_free) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Send one request and record its expected result
  task automatic send_request(input in_req_t rq);
    int g;
    g = gap_len();
    @(negedge clk);
    repeat (g) @(negedge clk);
    in_data <= rq;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(predict_result(rq));
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Result checker
  always @(posedge clk) begin
    out_res_t want;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result pc", out_data.program_counter, 0);
      end else begin
        want = expected_q.pop_front();
        if (out_data.read_value !== want.read_value)
          report_mismatch("read_value", out_data.read_value, want.read_value);
        if (out_data.program_counter !== want.program_counter)
          report_mismatch("program_counter", out_data.program_counter, want.program_counter);
        if (out_data.index_value !== want.index_value)
          report_mismatch("index_value", out_data.index_value, want.index_value);
        if (out_data.screen_changed !== want.screen_changed)
          report_mismatch("screen_changed", out_data.screen_changed, want.screen_changed);
        if (out_data.unsupported_op !== want.unsupported_op)
          report_mismatch("unsupported_op", out_data.unsupported_op, want.unsupported_op);
      end
    end
  end

  // Receiver back-pressure
  initial begin
    int g;
    forever begin
      @(negedge clk);
      g = gap_len();
      if (g > 0) begin
        out_stall <= 1'b1;
        repeat (g) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic in_req_t mk(input logic [2:0] cmd);
    in_req_t rq;
    rq = '0;
    rq.command = cmd;
    rq.mem_address = 12'($urandom);
    rq.mem_data = 8'($urandom);
    rq.pixel_column = 6'($urandom);
    rq.pixel_row = 5'($urandom);
    rq.reg_select = 4'($urandom);
    return rq;
  endfunction

  task automatic load_byte(input logic [11:0] a, input logic [7:0] d);
    in_req_t rq;
    rq = mk(CMD_LOAD);
    rq.mem_address = a;
    rq.mem_data = d;
    send_request(rq);
  endtask

  // Store an opcode at the current PC and execute it
  task automatic run_op(input logic [15:0] op);
    load_byte(mdl_pc, op[15:8]);
    load_byte(mdl_pc + 12'd1, op[7:0]);
    send_request(mk(CMD_EXEC));
    n_exec++;
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (2200) @(posedge clk);
  endtask

  task automatic write_start(input logic [11:0] a);
    drain();
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= a;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    mdl_start = a;
    send_request(mk(CMD_RESTART));
  endtask

  task automatic test_directed();
    in_req_t rq;
    for (int k = 0; k < 16; k++) load_byte(12'h300 + 12'(k), 8'($urandom));
    load_byte(12'hFFF, 8'hFF);
    run_op(16'h6AFF);            // load max
    run_op(16'h7A01);            // add wraps
    run_op(16'h6F80);
    run_op(16'h8FF4);            // flag wins on x = F
    run_op(16'hA300);
    run_op(16'h603C); run_op(16'h611E);
    run_op(16'hD01F);            // draw wrapping both edges
    run_op(16'hD01F);            // redraw: collision
    run_op(16'h00E0);
    run_op(16'h3000); run_op(16'h4000); run_op(16'h5017); run_op(16'h9013);
    run_op(16'h8016); run_op(16'hF000); run_op(16'h0123);
    rq = mk(CMD_PIXEL); rq.pixel_column = 6'd63; rq.pixel_row = 5'd31; send_request(rq);
    rq = mk(CMD_REG); rq.reg_select = 4'hF; send_request(rq);
    send_request(mk(3'd5)); send_request(mk(3'd7));
  endtask

  task automatic test_random(input int count);
    logic [15:0] op;
    int c;
    for (int k = 0; k < count; k++) begin
      c = $urandom_range(0, 99);
      if (c < 70) begin
        case ($urandom_range(0, 13))
          0: op = OPC_CLS;
          1: op = (stack_used > 0) ? OPC_RET : {OP_LD, 12'($urandom)};
          2: op = {OP_JP, 12'($urandom)};
          3: op = {OP_CALL, 12'($urandom)};
          4: op = {4'($urandom_range(OP_SE, OP_SER)), 12'($urandom)};
          5: op = {OP_SNER, 12'($urandom)};
          6, 7: op = {OP_LD, 12'($urandom)};
          8: op = {OP_ADD, 12'($urandom)};
          9: op = {OP_LDI, 12'($urandom)};
          10: op = {OP_DRW, 12'($urandom)};
          11, 12: op = {OP_ALU, 8'($urandom), 4'($urandom)};
          default: op = 16'($urandom);
        endcase
        // A return needs a stack entry written since the last restart
        if ((op == OPC_RET) && (stack_used == 0)) op = OPC_CLS;
        if (op[15:12] == OP_CALL) stack_used++;
        if (op == OPC_RET) stack_used--;
        // Sprite rows must come from written memory
        if (op[15:12] == OP_DRW)
          for (int r = 0; r < op[3:0]; r++)
            if (!mdl_written[mdl_i + 12'(r)]) load_byte(mdl_i + 12'(r), 8'($urandom));
        run_op(op);
      end else if (c < 80) send_request(mk(CMD_PIXEL));
      else if (c < 88) send_request(mk(CMD_REG));
      else if (c < 94) send_request(mk(CMD_LOAD));
      else if (c < 97) send_request(mk(CMD_RESTART));
      else send_request(mk(3'($urandom_range(5, 7))));
    end
  endtask

  task automatic test_no_stall();
    stall_free = 1'b1;
    test_random(20);
    stall_free = 1'b0;
  endtask

  initial begin
    foreach (mdl_mem[k]) begin mdl_mem[k] = '0; mdl_written[k] = 1'b0; end
    foreach (mdl_v[k]) mdl_v[k] = '0;
    foreach (mdl_scr[k]) mdl_scr[k] = 1'b0;
    foreach (mdl_stack[k]) mdl_stack[k] = '0;
    mdl_sp = '0; stack_used = 0; mdl_i = '0;
    mdl_start = START_RESET; mdl_pc = START_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(50);
    write_start(12'h000);
    test_random(50);
    write_start(12'hFFE);        // PC wraps past the top
    test_directed();
    write_start(12'hFFF);
    test_random(30);
    write_start(12'(($urandom & 12'hFFE)));
    test_random(50);
    test_no_stall();
    test_random(50);
    drain();
    $display("Covered %0d results, %0d executed instructions, five start addresses.",
             n_results, n_exec);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
